// ----- rtl/mbsd_pkg.sv -----
// Shared constants for the majority-rule block spin downsampler.
package mbsd_pkg;

    // Defaults for the top-level sizing parameters
    localparam int MAX_SIDE_DEF  = 256;
    localparam int MAX_BLOCK_DEF = 8;

    // Configuration port
    localparam int CFG_DATA_W = 9;
    localparam int CFG_IDX_W  = 1;
    localparam int LAT_SIZE_W = 9;
    localparam int BLK_FAC_W  = 4;

    localparam logic [CFG_IDX_W-1:0] REG_LATTICE_SIZE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_FACTOR = 1'b1;

    // Register reset values
    localparam int LAT_SIZE_RST = 256;
    localparam int BLK_FAC_RST  = 2;

    // Width of the reduced-lattice coordinates on the result port
    localparam int COORD_W = 8;

    // Depth of the queue between front and back
    localparam int QUEUE_DEPTH = 4;

endpackage

// ----- rtl/majority_block_spin_downsampler.sv -----
// Top level of the majority-rule block spin downsampler.
//
// Spins of a square lattice enter in raster order on the input channel
// (i_valid / o_ready), one spin per word, with a tie bit and a start mark.
// The lattice is cut into block_factor x block_factor blocks; when the
// bottom-right spin of a whole block is taken, one word leaves on the output
// channel (o_valid / i_ready) with the majority spin, its block row and
// column, a tie flag and a final-block flag. Spins outside whole blocks
// give no word.
// Configuration: i_cfg_we writes i_cfg_data to register i_cfg_idx
// (0 lattice_size, 1 block_factor); write only while idle.
// A write also restarts the raster position.
// Throughput is one spin per cycle while the queue is not full. The last
// spin of a block enters the queue when taken, is popped into the stage
// register together with the column-sum memory read, and its sum is then
// registered into the output word. The column-sum memory reads and writes
// one block column each cycle while the pipeline runs, with the last write
// forwarded to the next read.
// Reset (synchronous, active low) restores lattice_size 256, block_factor 2,
// the top-left position, and empties the queue and pipeline; no clearing
// pass is needed. While the receiver stalls, the output word holds, the
// pipeline stops, and spins keep entering until the short queue fills.
module majority_block_spin_downsampler
    import mbsd_pkg::*;
#(
    parameter int MAX_SIDE  = MAX_SIDE_DEF,
    parameter int MAX_BLOCK = MAX_BLOCK_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic                  i_spin_up,
    input  logic                  i_tie_choice,
    input  logic                  i_lattice_start,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic                  o_block_up,
    output logic [COORD_W-1:0]    o_block_row,
    output logic [COORD_W-1:0]    o_block_col,
    output logic                  o_was_tie,
    output logic                  o_last_block
);

    localparam int PW = $clog2(MAX_SIDE);

    typedef struct packed {
        logic          up;
        logic          tie;
        logic          first;
        logic          last;
        logic          last_blk;
        logic [PW-1:0] idx;
        logic [PW-1:0] brow;
    } t_op;

    logic w_accept, w_push, w_pop, w_full, w_q_valid;
    t_op  w_front_op, w_q_op;

    assign o_ready  = !w_full;
    assign w_accept = i_valid && !w_full;

    mbsd_front #(
        .MAX_SIDE  (MAX_SIDE),
        .MAX_BLOCK (MAX_BLOCK),
        .t_op      (t_op)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_accept        (w_accept),
        .i_spin_up       (i_spin_up),
        .i_tie_choice    (i_tie_choice),
        .i_lattice_start (i_lattice_start),
        .o_push          (w_push),
        .o_op            (w_front_op)
    );

    mbsd_queue #(
        .t_op (t_op)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_op    (w_front_op),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_valid (w_q_valid),
        .o_op    (w_q_op)
    );

    mbsd_back #(
        .MAX_SIDE  (MAX_SIDE),
        .MAX_BLOCK (MAX_BLOCK),
        .t_op      (t_op)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (w_q_valid),
        .i_q_op       (w_q_op),
        .o_pop        (w_pop),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_block_up   (o_block_up),
        .o_block_row  (o_block_row),
        .o_block_col  (o_block_col),
        .o_was_tie    (o_was_tie),
        .o_last_block (o_last_block)
    );

endmodule

// ----- rtl/mbsd_front.sv -----
// Front end: configuration registers, raster position tracking and block classification.
module mbsd_front
    import mbsd_pkg::*;
#(
    parameter int  MAX_SIDE  = MAX_SIDE_DEF,
    parameter int  MAX_BLOCK = MAX_BLOCK_DEF,
    parameter type t_op      = logic
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_accept,
    input  logic                  i_spin_up,
    input  logic                  i_tie_choice,
    input  logic                  i_lattice_start,
    output logic                  o_push,
    output t_op                   o_op
);

    localparam int SW   = $clog2(MAX_SIDE + 1);
    localparam int PW   = $clog2(MAX_SIDE);
    localparam int BW   = $clog2(MAX_BLOCK + 1);
    localparam int KW   = $clog2(MAX_BLOCK);
    localparam int FW   = ((SW > BW) ? SW : BW) + 1;
    localparam int FW2  = FW + 1;
    localparam int CMPW = (SW > LAT_SIZE_W) ? SW : LAT_SIZE_W;
    localparam int SIDE_RST  = (LAT_SIZE_RST > MAX_SIDE) ? MAX_SIDE : LAT_SIZE_RST;
    localparam int BLOCK_RST = (BLK_FAC_RST > MAX_BLOCK) ? MAX_BLOCK : BLK_FAC_RST;

    logic [SW-1:0] r_side;
    logic [BW-1:0] r_block;

    logic [PW-1:0] r_row, r_col, r_bcol, r_brow, r_row_base, r_col_base;
    logic [KW-1:0] r_rib, r_cib;

    logic [PW-1:0] w_row, w_col, w_bcol, w_brow, w_row_base, w_col_base;
    logic [KW-1:0] w_rib, w_cib;

    logic [PW-1:0] n_row, n_col, n_bcol, n_brow, n_row_base, n_col_base;
    logic [KW-1:0] n_rib, n_cib;

    logic [CMPW-1:0]      w_cfg_side;
    logic [BLK_FAC_W-1:0] w_cfg_block;
    logic                 w_row_fit, w_col_fit, w_row_more, w_col_more;
    logic                 w_rib_end, w_cib_end, w_col_end, w_row_end;

    assign w_cfg_side  = CMPW'(i_cfg_data[LAT_SIZE_W-1:0]);
    assign w_cfg_block = i_cfg_data[BLK_FAC_W-1:0];

    // A start mark zeroes the position before the spin is taken
    always_comb begin
        if (i_lattice_start) begin
            w_row = '0; w_col = '0; w_bcol = '0; w_brow = '0;
            w_row_base = '0; w_col_base = '0; w_rib = '0; w_cib = '0;
        end else begin
            w_row = r_row; w_col = r_col; w_bcol = r_bcol; w_brow = r_brow;
            w_row_base = r_row_base; w_col_base = r_col_base; w_rib = r_rib; w_cib = r_cib;
        end
    end

    // A block is whole when its far edge stays inside the lattice
    assign w_row_fit  = (FW'(w_row_base) + FW'(r_block)) <= FW'(r_side);
    assign w_col_fit  = (FW'(w_col_base) + FW'(r_block)) <= FW'(r_side);
    assign w_row_more = (FW2'(w_row_base) + (FW2'(r_block) << 1)) <= FW2'(r_side);
    assign w_col_more = (FW2'(w_col_base) + (FW2'(r_block) << 1)) <= FW2'(r_side);

    assign w_rib_end = ((BW + 1)'(w_rib) + (BW + 1)'(1)) >= (BW + 1)'(r_block);
    assign w_cib_end = ((BW + 1)'(w_cib) + (BW + 1)'(1)) >= (BW + 1)'(r_block);
    assign w_col_end = (SW'(w_col) + SW'(1)) >= r_side;
    assign w_row_end = (SW'(w_row) + SW'(1)) >= r_side;

    always_comb begin
        o_op          = '0;
        o_op.up       = i_spin_up;
        o_op.tie      = i_tie_choice;
        o_op.first    = (w_rib == '0) && (w_cib == '0);
        o_op.last     = w_rib_end && w_cib_end;
        o_op.last_blk = w_rib_end && w_cib_end && !w_row_more && !w_col_more;
        o_op.idx      = w_bcol;
        o_op.brow     = w_brow;
    end

    assign o_push = i_accept && w_row_fit && w_col_fit;

    // Advance the raster position
    always_comb begin
        n_row = w_row; n_col = w_col + PW'(1); n_bcol = w_bcol; n_brow = w_brow;
        n_row_base = w_row_base; n_col_base = w_col_base;
        n_rib = w_rib; n_cib = w_cib + KW'(1);
        if (w_cib_end) begin
            n_cib      = '0;
            n_bcol     = w_bcol + PW'(1);
            n_col_base = w_col_base + PW'(r_block);
        end
        if (w_col_end) begin
            n_col      = '0;
            n_cib      = '0;
            n_bcol     = '0;
            n_col_base = '0;
            n_row      = w_row + PW'(1);
            n_rib      = w_rib + KW'(1);
            if (w_rib_end) begin
                n_rib      = '0;
                n_brow     = w_brow + PW'(1);
                n_row_base = w_row_base + PW'(r_block);
            end
            if (w_row_end) begin
                n_row      = '0;
                n_rib      = '0;
                n_brow     = '0;
                n_row_base = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side  <= SW'(SIDE_RST);
            r_block <= BW'(BLOCK_RST);
            r_row <= '0; r_col <= '0; r_bcol <= '0; r_brow <= '0;
            r_row_base <= '0; r_col_base <= '0; r_rib <= '0; r_cib <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_LATTICE_SIZE: begin
                    if (w_cfg_side == '0)
                        r_side <= SW'(1);
                    else if (w_cfg_side > CMPW'(MAX_SIDE))
                        r_side <= SW'(MAX_SIDE);
                    else
                        r_side <= SW'(w_cfg_side);
                end
                REG_BLOCK_FACTOR: begin
                    if (w_cfg_block == '0)
                        r_block <= BW'(1);
                    else if ((BW + BLK_FAC_W)'(w_cfg_block) > (BW + BLK_FAC_W)'(MAX_BLOCK))
                        r_block <= BW'(MAX_BLOCK);
                    else
                        r_block <= BW'(w_cfg_block);
                end
                default: begin
                    r_side <= r_side;
                end
            endcase
            // any register write restarts the lattice
            r_row <= '0; r_col <= '0; r_bcol <= '0; r_brow <= '0;
            r_row_base <= '0; r_col_base <= '0; r_rib <= '0; r_cib <= '0;
        end else if (i_accept) begin
            r_row <= n_row; r_col <= n_col; r_bcol <= n_bcol; r_brow <= n_brow;
            r_row_base <= n_row_base; r_col_base <= n_col_base;
            r_rib <= n_rib; r_cib <= n_cib;
        end
    end

endmodule

// ----- rtl/mbsd_queue.sv -----
// Short queue carrying classified spin words from front to back.
module mbsd_queue
    import mbsd_pkg::*;
#(
    parameter type t_op = logic
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_op  i_op,
    input  logic i_pop,
    output logic o_full,
    output logic o_valid,
    output t_op  o_op
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_op           r_mem [QUEUE_DEPTH];
    logic [AW-1:0] r_wr_ptr, r_rd_ptr;
    logic [CW-1:0] r_cnt;

    assign o_full  = (r_cnt == CW'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_op    = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push)
            r_mem[r_wr_ptr] <= i_op;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (i_push)
                r_wr_ptr <= r_wr_ptr + AW'(1);
            if (i_pop)
                r_rd_ptr <= r_rd_ptr + AW'(1);
            if (i_push && !i_pop)
                r_cnt <= r_cnt + CW'(1);
            else if (i_pop && !i_push)
                r_cnt <= r_cnt - CW'(1);
        end
    end

endmodule

// ----- rtl/mbsd_back.sv -----
// Back end: column-sum memory with read-modify-write, majority decision and output register.
module mbsd_back
    import mbsd_pkg::*;
#(
    parameter int  MAX_SIDE  = MAX_SIDE_DEF,
    parameter int  MAX_BLOCK = MAX_BLOCK_DEF,
    parameter type t_op      = logic
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_valid,
    input  t_op                i_q_op,
    output logic               o_pop,
    output logic               o_valid,
    input  logic               i_ready,
    output logic               o_block_up,
    output logic [COORD_W-1:0] o_block_row,
    output logic [COORD_W-1:0] o_block_col,
    output logic               o_was_tie,
    output logic               o_last_block
);

    localparam int PW   = $clog2(MAX_SIDE);
    localparam int SUMW = $clog2(MAX_BLOCK * MAX_BLOCK + 1) + 1;

    logic [SUMW-1:0] r_sums [MAX_SIDE];
    logic [SUMW-1:0] r_rd_data;

    logic            r_s1_vld;
    t_op             r_s1;
    logic            r_wr_vld;
    logic [PW-1:0]   r_wr_idx;
    logic [SUMW-1:0] r_wr_val;

    logic               r_ovld, r_up, r_tie, r_last;
    logic [COORD_W-1:0] r_row, r_col;

    logic            w_en;
    logic [SUMW-1:0] w_base, w_step, w_sum;
    logic            w_zero, w_pos;

    assign w_en  = !r_ovld || i_ready;
    assign o_pop = w_en && i_q_valid;

    // Start from zero on a block's first spin, else take the word just written when the read raced the write
    always_comb begin
        if (r_s1.first)
            w_base = '0;
        else if (r_wr_vld && (r_wr_idx == r_s1.idx))
            w_base = r_wr_val;
        else
            w_base = r_rd_data;
    end

    // down spin adds minus one (all ones)
    assign w_step = r_s1.up ? SUMW'(1) : {SUMW{1'b1}};
    assign w_sum  = w_base + w_step;
    assign w_zero = (w_sum == '0);
    assign w_pos  = !w_sum[SUMW-1] && !w_zero;

    always_ff @(posedge i_clk) begin
        if (w_en && r_s1_vld)
            r_sums[r_s1.idx] <= w_sum;
        if (o_pop)
            r_rd_data <= r_sums[i_q_op.idx];
    end

    always_ff @(posedge i_clk) begin
        if (o_pop)
            r_s1 <= i_q_op;
        if (w_en && r_s1_vld) begin
            r_wr_idx <= r_s1.idx;
            r_wr_val <= w_sum;
        end
        if (w_en && r_s1_vld && r_s1.last) begin
            r_up   <= w_zero ? r_s1.tie : w_pos;
            r_tie  <= w_zero;
            r_last <= r_s1.last_blk;
            r_row  <= COORD_W'(r_s1.brow);
            r_col  <= COORD_W'(r_s1.idx);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_wr_vld <= 1'b0;
            r_ovld   <= 1'b0;
        end else if (w_en) begin
            r_s1_vld <= i_q_valid;
            if (r_s1_vld)
                r_wr_vld <= 1'b1;
            r_ovld <= r_s1_vld && r_s1.last;
        end
    end

    assign o_valid      = r_ovld;
    assign o_block_up   = r_up;
    assign o_block_row  = r_row;
    assign o_block_col  = r_col;
    assign o_was_tie    = r_tie;
    assign o_last_block = r_last;

    a_last_gives_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_en && r_s1_vld && r_s1.last) |=> r_ovld)
        else $error("finished block did not reach the output register");

    a_no_spurious_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_en && !(r_s1_vld && r_s1.last)) |=> !r_ovld)
        else $error("output word without a finished block");

    a_last_block_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_vld && r_s1.last_blk) |-> r_s1.last)
        else $error("final block flag on a spin that does not close a block");

endmodule
